// ===== sv/hhr_pkg.sv =====
// Package: shared constants and types of the HSL/HWB to RGB8 converter.
package hhr_pkg;

    // Field widths of the request and result channels
    localparam int FIELD_W = 13;
    localparam int HUE_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int T_W     = 10;

    // Conversion modes
    localparam logic OP_HSL = 1'b0;
    localparam logic OP_HWB = 1'b1;

    // Hue geometry in tenths of a degree
    localparam int HUE_FULL   = 3600;
    localparam int HUE_SECTOR = 600;
    localparam int HUE_DBL    = 1200;
    localparam int HUE_BIAS   = 36000;   // ten full turns, makes any 16-bit hue positive
    localparam int HUE_X_W    = 17;

    // Reciprocal of 3600: floor(2^26 / 3600), estimate is exact or one low
    localparam int HUE_RECIP       = 18641;
    localparam int HUE_RECIP_SHIFT = 26;
    localparam int HUE_Q_W         = 5;

    // Byte scaling: 2 * 255, and the odd factor left once the power of two is shifted out
    localparam int BYTE_X2     = 510;
    localparam int BYTE_MAX    = 255;
    localparam int DEN_ODD     = 75;
    localparam int Y_W         = 15;
    // ceil(2^24 / 75), exact floor division for any 15-bit value
    localparam int DIV75_RECIP = 223697;
    localparam int DIV75_SHIFT = 24;

    localparam int N_STAGES = 9;

    // Channel output selection carried with the data into the channel units
    typedef struct packed {
        logic                hwb;
        logic                gray;
        logic [BYTE_W-1:0]   gray_byte;
    } t_chan_sel;

    // Tail of the pipeline: gray flag and finished alpha byte
    typedef struct packed {
        logic                gray;
        logic [BYTE_W-1:0]   alpha;
    } t_tail;

endpackage

// ===== sv/hhr_in_if.sv =====
// Interface: request channel carrying one colour to convert.
interface hhr_in_if;
    import hhr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       op;
    logic signed [HUE_W-1:0]    hue;
    logic [FIELD_W-1:0]         saturation;
    logic [FIELD_W-1:0]         lightness;
    logic [FIELD_W-1:0]         whiteness;
    logic [FIELD_W-1:0]         blackness;
    logic [FIELD_W-1:0]         alpha_in;

    modport source (
        output valid, op, hue, saturation, lightness, whiteness, blackness, alpha_in,
        input  ready
    );

    modport sink (
        input  valid, op, hue, saturation, lightness, whiteness, blackness, alpha_in,
        output ready
    );

endinterface

// ===== sv/hhr_out_if.sv =====
// Interface: result channel carrying one RGBA8 pixel.
interface hhr_out_if;
    import hhr_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   red;
    logic [BYTE_W-1:0]   green;
    logic [BYTE_W-1:0]   blue;
    logic [BYTE_W-1:0]   alpha_out;

    modport source (
        output valid, red, green, blue, alpha_out,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, alpha_out,
        output ready
    );

endinterface

// ===== sv/hhr_div.sv =====
// Module: one registered stage of the gray-level divider, two quotient bits.
module hhr_div
    import hhr_pkg::*;
#(
    parameter int UNIT_BITS = 12,
    parameter int BIT_HI    = 7
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [UNIT_BITS+9:0]    i_rem,
    input  logic [UNIT_BITS+2:0]    i_dvs,
    input  logic [BYTE_W-1:0]       i_quo,
    output logic [UNIT_BITS+9:0]    o_rem,
    output logic [UNIT_BITS+2:0]    o_dvs,
    output logic [BYTE_W-1:0]       o_quo
);

    localparam int RW = UNIT_BITS + 10;

    logic [RW-1:0]      rem;
    logic [BYTE_W-1:0]  quo;

    // Restoring steps: subtract the shifted divisor where it fits
    always_comb begin
        logic [RW-1:0] sh;
        rem = i_rem;
        quo = i_quo;
        for (int j = 0; j < 2; j++) begin
            sh = RW'(i_dvs) << (BIT_HI - j);
            if (rem >= sh) begin
                rem = rem - sh;
                quo[BIT_HI - j] = 1'b1;
            end
        end
    end

    // Advance the partial result
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= rem;
            o_dvs <= i_dvs;
            o_quo <= quo;
        end
    end

endmodule

// ===== sv/hhr_chan.sv =====
// Module: per-channel back end, numerator, scaling to a byte and rounding.
module hhr_chan
    import hhr_pkg::*;
#(
    parameter int UNIT_BITS = 12
) (
    input  logic                    i_clk,
    input  logic [2:0]              i_en,
    input  t_chan_sel               i_sel,
    input  logic [T_W-1:0]          i_t,
    input  logic [2*UNIT_BITS:0]    i_p,
    input  logic [UNIT_BITS:0]      i_l,
    input  logic [UNIT_BITS:0]      i_m,
    input  logic [UNIT_BITS:0]      i_w,
    output logic [BYTE_W-1:0]       o_byte
);

    localparam int NW = 2 * UNIT_BITS + 13;
    localparam int XW = NW + 9;
    localparam int QW = 34;

    logic [NW-1:0]      r_num;
    logic [Y_W-1:0]     r_y;
    t_chan_sel          r_sel7;
    t_chan_sel          r_sel8;

    logic [NW-1:0]      num;
    logic [XW-1:0]      x_scaled;
    logic [QW-1:0]      q_prod;
    logic [8:0]         q_raw;
    logic [BYTE_W-1:0]  q_byte;

    // Form the numerator over the common denominator 75 * 2^(2U+4)
    always_comb begin
        logic signed [11:0]    d_ramp;
        logic signed [NW-1:0]  p_s;
        logic signed [NW-1:0]  d_s;
        logic signed [NW-1:0]  lt;
        logic [NW-1:0]         hwb_num;
        d_ramp  = $signed({1'b0, i_t, 1'b0}) - 12'sd600;
        p_s     = NW'($signed({1'b0, i_p}));
        d_s     = NW'(d_ramp);
        lt      = $signed((NW'(i_l) * NW'(HUE_DBL)) << UNIT_BITS);
        hwb_num = (NW'(i_t) * NW'(i_m) + NW'(i_w) * NW'(HUE_SECTOR)) << (UNIT_BITS + 1);
        if (i_sel.hwb == OP_HWB) begin
            num = hwb_num;
        end else begin
            num = lt + p_s * d_s;
        end
    end

    // Scale by 510, add the denominator for rounding, drop the power of two
    assign x_scaled = XW'(r_num) * XW'(BYTE_X2) + (XW'(DEN_ODD) << (2 * UNIT_BITS + 4));

    // Divide by 75 with the reciprocal and saturate
    assign q_prod = QW'(r_y) * QW'(DIV75_RECIP);
    assign q_raw  = q_prod[DIV75_SHIFT +: 9];
    assign q_byte = (q_raw > 9'(BYTE_MAX)) ? BYTE_W'(BYTE_MAX) : q_raw[BYTE_W-1:0];

    // Advance the three back-end stages
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_num  <= num;
            r_sel7 <= i_sel;
        end
        if (i_en[1]) begin
            r_y    <= x_scaled[2 * UNIT_BITS + 5 +: Y_W];
            r_sel8 <= r_sel7;
        end
        if (i_en[2]) begin
            o_byte <= (r_sel8.hwb == OP_HWB && r_sel8.gray) ? r_sel8.gray_byte : q_byte;
        end
    end

endmodule

// ===== sv/hsl_hwb_to_rgb8.sv =====
// Top level: HSL/HWB to RGBA8 converter, nine-stage pipeline.
//
//   port    dir  role    fields
//   i_in    in   sink    op, hue, saturation, lightness, whiteness, blackness, alpha_in
//   o_out   out  source  red, green, blue, alpha_out
//
// One request per clock while the result side accepts; a result leaves from the last of
// the nine register stages, in order: input clamp, hue wrap multiply, gray divider
// (two bits a stage over four stages, beside the hue remainder and sector split) and
// the channel multiply and reciprocal divide.
// Reset clears only the stage valid bits. Each stage advances when it is empty or
// the next one advances, so a stalled output lets new requests fill empty stages behind it.
module hsl_hwb_to_rgb8
    import hhr_pkg::*;
#(
    parameter int UNIT_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hhr_in_if.sink      i_in,
    hhr_out_if.source   o_out
);

    localparam int ONE = 1 << UNIT_BITS;
    localparam int CW  = UNIT_BITS + 1;
    localparam int SW  = UNIT_BITS + 2;
    localparam int VW  = UNIT_BITS + 3;
    localparam int AW  = UNIT_BITS + 9;
    localparam int RW  = UNIT_BITS + 10;
    localparam int EW  = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int PW  = 2 * UNIT_BITS + 1;

    typedef struct packed {
        logic           hwb;
        logic           gray;
        logic [7:0]     alpha;
        logic [CW-1:0]  l;
        logic [PW-1:0]  p;
        logic [CW-1:0]  m;
        logic [CW-1:0]  w;
    } t_carry;

    // Clamp a unit value to 1.0
    function automatic logic [CW-1:0] clamp_unit(input logic [FIELD_W-1:0] raw);
        logic [EW-1:0] ext;
        ext = EW'(raw);
        return (ext > EW'(ONE)) ? CW'(ONE) : ext[CW-1:0];
    endfunction

    logic [N_STAGES:1]  r_v;
    logic [N_STAGES:1]  stage_en;
    logic [N_STAGES:0]  v_chain;

    // Stage 1
    logic                   r1_hwb;
    logic [HUE_X_W-1:0]     r1_x;
    logic [CW-1:0]          r1_s, r1_l, r1_w, r1_b, r1_a;
    // Stage 2
    logic                   r2_hwb, r2_gray;
    logic [HUE_X_W-1:0]     r2_x;
    logic [HUE_Q_W-1:0]     r2_qh;
    logic [CW-1:0]          r2_s, r2_l, r2_a, r2_m, r2_w;
    logic [7:0]             r2_alpha;
    logic [RW-1:0]          r2_d;
    logic [VW-1:0]          r2_dvs;
    // Stages 3 to 6
    logic [12:0]            r3_r;
    logic [11:0]            r4_h;
    logic [2:0]             r5_sec;
    logic [T_W-1:0]         r5_f;
    logic [T_W-1:0]         r6_t [3];
    t_carry                 r_c [3:6];
    // Stages 7 to 9
    t_tail                  r_tail [7:9];

    logic [RW-1:0]          div_rem [2:6];
    logic [VW-1:0]          div_dvs [2:6];
    logic [BYTE_W-1:0]      div_quo [2:6];
    logic [BYTE_W-1:0]      chan_byte [3];

    logic [SW-1:0]          sum_wb;
    logic [SW-1:0]          m_full;
    logic [CW-1:0]          a_hsl;
    logic [AW-1:0]          alpha_sc;
    logic [31:0]            hue_prod;
    logic [2:0]             sec;
    logic [T_W-1:0]         t_next [3];
    t_chan_sel              chan_sel;

    // Stage enables: advance when empty or when the next stage advances
    always_comb begin
        stage_en[N_STAGES] = !r_v[N_STAGES] || o_out.ready;
        for (int k = N_STAGES - 1; k >= 1; k--) begin
            stage_en[k] = !r_v[k] || stage_en[k+1];
        end
    end

    assign v_chain   = {r_v, i_in.valid};
    assign i_in.ready = stage_en[1];

    // Move valid bits along the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= N_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_v[k] <= v_chain[k-1];
                end
            end
        end
    end

    // Stage 1: clamp unit values, bias the hue positive
    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r1_hwb <= i_in.op;
            r1_x   <= HUE_X_W'(i_in.hue) + HUE_X_W'(HUE_BIAS);
            r1_s   <= clamp_unit(i_in.saturation);
            r1_l   <= clamp_unit(i_in.lightness);
            r1_w   <= clamp_unit(i_in.whiteness);
            r1_b   <= clamp_unit(i_in.blackness);
            r1_a   <= clamp_unit(i_in.alpha_in);
        end
    end

    // Stage 2 logic: hue quotient estimate, gray test, divider operands, HSL chroma factor
    assign hue_prod = 32'(r1_x) * 32'(HUE_RECIP);
    assign sum_wb   = SW'(r1_w) + SW'(r1_b);
    assign m_full   = SW'(ONE) - sum_wb;
    assign alpha_sc = AW'(r1_a) * AW'(BYTE_X2) + AW'(ONE);
    assign a_hsl    = (r1_l >= CW'(ONE / 2)) ? ((CW'(ONE) - r1_l) << 1) : (r1_l << 1);

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            r2_hwb   <= r1_hwb;
            r2_x     <= r1_x;
            r2_qh    <= hue_prod[HUE_RECIP_SHIFT +: HUE_Q_W];
            r2_gray  <= (sum_wb >= SW'(ONE));
            r2_d     <= RW'(r1_w) * RW'(BYTE_X2) + RW'(sum_wb);
            r2_dvs   <= {sum_wb, 1'b0};
            r2_m     <= m_full[CW-1:0];
            r2_s     <= r1_s;
            r2_l     <= r1_l;
            r2_a     <= a_hsl;
            r2_w     <= r1_w;
            r2_alpha <= alpha_sc[UNIT_BITS + 1 +: 8];
        end
    end

    // Gray divider: round(255 * w / (w + b)), two quotient bits a stage
    assign div_rem[2] = r2_d;
    assign div_dvs[2] = r2_dvs;
    assign div_quo[2] = '0;

    for (genvar g = 3; g <= 6; g++) begin : g_div
        hhr_div #(
            .UNIT_BITS (UNIT_BITS),
            .BIT_HI    (7 - 2 * (g - 3))
        ) u_div (
            .i_clk (i_clk),
            .i_en  (stage_en[g]),
            .i_rem (div_rem[g-1]),
            .i_dvs (div_dvs[g-1]),
            .i_quo (div_quo[g-1]),
            .o_rem (div_rem[g]),
            .o_dvs (div_dvs[g]),
            .o_quo (div_quo[g])
        );
    end

    // Stage 3: hue remainder, chroma product, carried fields
    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            r3_r       <= 13'(r2_x - HUE_X_W'(r2_qh) * HUE_X_W'(HUE_FULL));
            r_c[3].hwb   <= r2_hwb;
            r_c[3].gray  <= r2_gray;
            r_c[3].alpha <= r2_alpha;
            r_c[3].l     <= r2_l;
            r_c[3].p     <= PW'((2 * CW)'(r2_a) * (2 * CW)'(r2_s));
            r_c[3].m     <= r2_m;
            r_c[3].w     <= r2_w;
        end
    end

    // Stage 4: correct a low quotient estimate
    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r4_h   <= (r3_r >= 13'(HUE_FULL)) ? 12'(r3_r - 13'(HUE_FULL)) : r3_r[11:0];
            r_c[4] <= r_c[3];
        end
    end

    // Stage 5: split hue into sector and position within it
    always_comb begin
        sec = '0;
        for (int k = 1; k <= 5; k++) begin
            if (r4_h >= 12'(k * HUE_SECTOR)) begin
                sec = 3'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            r5_sec <= sec;
            r5_f   <= T_W'(r4_h - 12'(sec) * 12'(HUE_SECTOR));
            r_c[5] <= r_c[4];
        end
    end

    // Stage 6: ramp position of the saturated base colour per channel
    always_comb begin
        t_next[0] = '0;
        t_next[1] = '0;
        t_next[2] = '0;
        unique case (r5_sec)
            3'd0: begin
                t_next[0] = T_W'(HUE_SECTOR);
                t_next[1] = r5_f;
            end
            3'd1: begin
                t_next[0] = T_W'(HUE_SECTOR) - r5_f;
                t_next[1] = T_W'(HUE_SECTOR);
            end
            3'd2: begin
                t_next[1] = T_W'(HUE_SECTOR);
                t_next[2] = r5_f;
            end
            3'd3: begin
                t_next[1] = T_W'(HUE_SECTOR) - r5_f;
                t_next[2] = T_W'(HUE_SECTOR);
            end
            3'd4: begin
                t_next[0] = r5_f;
                t_next[2] = T_W'(HUE_SECTOR);
            end
            default: begin
                t_next[0] = T_W'(HUE_SECTOR);
                t_next[2] = T_W'(HUE_SECTOR) - r5_f;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[6]) begin
            r6_t   <= t_next;
            r_c[6] <= r_c[5];
        end
    end

    // Stages 7 to 9: channel back ends and the alpha tail
    assign chan_sel.hwb       = r_c[6].hwb;
    assign chan_sel.gray      = r_c[6].gray;
    assign chan_sel.gray_byte = div_quo[6];

    for (genvar c = 0; c < 3; c++) begin : g_chan
        hhr_chan #(
            .UNIT_BITS (UNIT_BITS)
        ) u_chan (
            .i_clk  (i_clk),
            .i_en   (stage_en[9:7]),
            .i_sel  (chan_sel),
            .i_t    (r6_t[c]),
            .i_p    (r_c[6].p),
            .i_l    (r_c[6].l),
            .i_m    (r_c[6].m),
            .i_w    (r_c[6].w),
            .o_byte (chan_byte[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[7]) begin
            r_tail[7].gray  <= (r_c[6].hwb == OP_HWB) && r_c[6].gray;
            r_tail[7].alpha <= r_c[6].alpha;
        end
        if (stage_en[8]) begin
            r_tail[8] <= r_tail[7];
        end
        if (stage_en[9]) begin
            r_tail[9] <= r_tail[8];
        end
    end

    // Drive the result channel
    assign o_out.valid     = r_v[N_STAGES];
    assign o_out.red       = chan_byte[0];
    assign o_out.green     = chan_byte[1];
    assign o_out.blue      = chan_byte[2];
    assign o_out.alpha_out = r_tail[9].alpha;

    // Request refused only when every stage holds an item
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (&r_v))
        else $error("request stalled with an empty stage");

    // Gray results carry one value on all three colour channels
    a_gray_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_tail[9].gray) |->
            (o_out.red == o_out.green) && (o_out.green == o_out.blue))
        else $error("gray result with unequal channels");

    // Divider finishes with a remainder below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[6] && r_c[6].hwb == OP_HWB && r_c[6].gray) |->
            (div_rem[6] < RW'(div_dvs[6])))
        else $error("gray divider remainder out of range");

endmodule
